// ----- design/threshold_fsm_with_hysteresis_core_macros.svh -----
// Assertion macros for the threshold state machine core.
// Used by the top level only; they expect clk and arst_n in scope.
`ifndef THRESHOLD_FSM_WITH_HYSTERESIS_CORE_MACROS_SVH
`define THRESHOLD_FSM_WITH_HYSTERESIS_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define TFSMH_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define TFSMH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/tfsmh_pkg.sv -----
// Shared types and constants for the threshold state machine core.
// No dependencies; used by tfsmh_table and the top level.
package tfsmh_pkg;

	localparam int NUM_STATES      = 8;
	localparam int SLOTS_PER_STATE = 8;
	localparam int DIST_WIDTH      = 16;

	localparam int TBL_DEPTH = NUM_STATES * SLOTS_PER_STATE;
	localparam int ADDR_W    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
	localparam int SLOT_W    = (SLOTS_PER_STATE > 1) ? $clog2(SLOTS_PER_STATE) : 1;

	localparam logic [15:0] DIST_MASK =
		(DIST_WIDTH >= 16) ? 16'hFFFF : 16'((32'd1 << DIST_WIDTH) - 32'd1);

	localparam int  PADDR_W  = 3;
	localparam logic REG_HYST = 1'b0;

	typedef enum logic [2:0] {
		KIND_EMPTY = 3'd0,
		KIND_EQ    = 3'd1,
		KIND_LT    = 3'd2,
		KIND_GT    = 3'd3,
		KIND_LE    = 3'd4,
		KIND_GE    = 3'd5,
		KIND_NE    = 3'd6
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} scan_state_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] thr;
		logic [2:0]  target;
	} entry_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		entry_t            data;
	} tbl_wr_t;

endpackage

// ----- design/threshold_fsm_with_hysteresis_core.sv -----
// Threshold state machine with hysteresis: table-driven transitions per state.
// Table write: taken in one cycle, no result; another item may follow the next cycle.
// Sample: result 2 to SLOTS_PER_STATE+1 cycles after acceptance (one scan cycle per list
// entry visited, one update cycle), next item 3 to SLOTS_PER_STATE+2 cycles after, set by
// the single read port of the transition table; a stalled result holds the update step.
// Reset clears all state and marks every table entry empty at once. Uses tfsmh_pkg, tfsmh_table.
`include "threshold_fsm_with_hysteresis_core_macros.svh"

module threshold_fsm_with_hysteresis_core (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [15:0] distance,
	input  logic [2:0]  entry_state,
	input  logic [2:0]  entry_slot,
	input  logic [2:0]  entry_kind,
	input  logic [15:0] entry_threshold,
	input  logic [2:0]  entry_target,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  state_now,
	output logic        changed,
	output logic        fired,
	output logic [2:0]  fired_slot,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [tfsmh_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import tfsmh_pkg::*;

	scan_state_t fsm_q, fsm_nxt;

	logic [15:0] hyst_q;

	logic [2:0]  present_q;
	logic [2:0]  prior_q;
	logic        ret_vld_q;
	logic [2:0]  ret_state_q;
	logic [2:0]  saved_kind_q;
	logic [15:0] saved_thr_q;

	logic [15:0]       dist_q;
	logic [SLOT_W-1:0] slot_q;
	logic              hit_q;
	logic [2:0]        hit_kind_q;
	logic [15:0]       hit_thr_q;
	logic [2:0]        hit_tgt_q;

	logic        out_valid_q;
	logic [2:0]  state_now_q;
	logic        changed_q;
	logic        fired_q;
	logic [2:0]  fired_slot_q;

	tbl_wr_t           tbl_wr;
	logic [ADDR_W-1:0] rd_addr;
	entry_t            rd_entry;

	logic in_acc, sample_acc, out_acc;
	logic cfg_wr;

	// scan evaluation
	logic              match, list_end, last_slot, scan_done;
	logic [SLOT_W-1:0] rd_slot;
	logic signed [17:0] d_ext, thr_ext, h_ext, thr_lo, thr_hi;

	// update step
	logic               out_free, load_out;
	logic [2:0]         upd_state;
	logic               state_chg;
	logic [2:0]         chk_kind;
	logic signed [17:0] chk_thr, chk_lo, chk_hi, hy_ext;
	logic               ret_clear, track_skip;

	assign in_acc     = in_valid && !in_stall;
	assign sample_acc = in_acc && !operation;
	assign out_acc    = out_valid_q && !out_stall;
	assign cfg_wr     = psel && penable && pwrite && pready;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_HYST) ? {16'b0, hyst_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hyst_q <= '0;
		end else if (cfg_wr && paddr[2] == REG_HYST) begin
			hyst_q <= pwdata[15:0];
		end
	end

	// ---------------- table ----------------
	always_comb begin
		tbl_wr.en = in_acc && operation
			&& (int'(entry_state) < NUM_STATES)
			&& (int'(entry_slot) < SLOTS_PER_STATE)
			&& (int'(entry_target) < NUM_STATES);
		tbl_wr.addr = ADDR_W'(entry_state) * ADDR_W'(SLOTS_PER_STATE)
			+ ADDR_W'(entry_slot);
		tbl_wr.data.kind   = entry_kind;
		tbl_wr.data.thr    = entry_threshold & DIST_MASK;
		tbl_wr.data.target = entry_target;
	end

	tfsmh_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (tbl_wr),
		.rd_addr  (rd_addr),
		.rd_entry (rd_entry)
	);

	// ---------------- scan compare ----------------
	always_comb begin
		d_ext   = $signed({2'b00, dist_q});
		thr_ext = $signed({2'b00, rd_entry.thr});
		h_ext   = (ret_vld_q && ret_state_q == rd_entry.target)
			? $signed({2'b00, hyst_q}) : 18'sd0;
		thr_lo  = thr_ext - h_ext;
		thr_hi  = thr_ext + h_ext;
		unique case (rd_entry.kind)
			KIND_EQ: match = (d_ext == thr_ext);
			KIND_LT: match = (d_ext <  thr_lo);
			KIND_GT: match = (d_ext >  thr_hi);
			KIND_LE: match = (d_ext <= thr_lo);
			KIND_GE: match = (d_ext >= thr_hi);
			KIND_NE: match = (d_ext != thr_ext);
			default: match = 1'b0;
		endcase
		list_end  = (rd_entry.kind == KIND_EMPTY);
		last_slot = (int'(slot_q) == SLOTS_PER_STATE - 1);
		scan_done = match || list_end || last_slot;
	end

	// ---------------- returning-state update ----------------
	always_comb begin
		upd_state  = hit_q ? hit_tgt_q : present_q;
		state_chg  = (upd_state != present_q);
		chk_kind   = hit_q ? hit_kind_q : saved_kind_q;
		chk_thr    = $signed({2'b00, (hit_q ? hit_thr_q : saved_thr_q)});
		hy_ext     = $signed({2'b00, hyst_q});
		chk_lo     = chk_thr - hy_ext;
		chk_hi     = chk_thr + hy_ext;
		unique case (chk_kind)
			KIND_LT, KIND_LE: ret_clear = (d_ext <= chk_lo);
			KIND_GT, KIND_GE: ret_clear = (d_ext >= chk_hi);
			default:          ret_clear = 1'b1;
		endcase
		track_skip = !ret_vld_q && (hyst_q != 16'd0);
	end

	// ---------------- sequencer ----------------
	always_comb begin
		fsm_nxt = fsm_q;
		unique case (fsm_q)
			ST_IDLE:   if (sample_acc) fsm_nxt = ST_SCAN;
			ST_SCAN:   if (scan_done) fsm_nxt = ST_FINISH;
			ST_FINISH: if (out_free) fsm_nxt = ST_IDLE;
			default:   fsm_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		out_free = !out_valid_q || !out_stall;
		in_stall = (fsm_q != ST_IDLE);
		load_out = (fsm_q == ST_FINISH) && out_free;
		// read ahead one slot while the current one is evaluated
		rd_slot  = (fsm_q == ST_SCAN && !last_slot) ? slot_q + 1'b1 : '0;
		rd_addr  = ADDR_W'(present_q) * ADDR_W'(SLOTS_PER_STATE) + ADDR_W'(rd_slot);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q <= ST_IDLE;
		end else begin
			fsm_q <= fsm_nxt;
		end
	end

	// per-sample working registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			hit_q  <= 1'b0;
		end else if (sample_acc) begin
			slot_q <= '0;
			hit_q  <= 1'b0;
		end else if (fsm_q == ST_SCAN) begin
			if (match) begin
				hit_q <= 1'b1;
			end else if (!scan_done) begin
				slot_q <= slot_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample_acc) begin
			dist_q <= distance & DIST_MASK;
		end
		if (fsm_q == ST_SCAN && match) begin
			hit_kind_q <= rd_entry.kind;
			hit_thr_q  <= rd_entry.thr;
			hit_tgt_q  <= rd_entry.target;
		end
	end

	// machine state and returning-state bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q    <= '0;
			prior_q      <= '0;
			ret_vld_q    <= 1'b0;
			ret_state_q  <= '0;
			saved_kind_q <= KIND_EMPTY;
			saved_thr_q  <= '0;
		end else if (load_out) begin
			present_q <= upd_state;
			if (state_chg) begin
				prior_q      <= present_q;
				ret_state_q  <= present_q;
				saved_kind_q <= hit_kind_q;
				saved_thr_q  <= hit_thr_q;
				ret_vld_q    <= !ret_clear;
			end else if (!track_skip) begin
				if (hit_q) begin
					ret_state_q  <= prior_q;
					saved_kind_q <= hit_kind_q;
					saved_thr_q  <= hit_thr_q;
				end
				// without a hit, only drop a returning state, never raise one
				ret_vld_q <= (hit_q || ret_vld_q) && !ret_clear;
			end
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_acc) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			state_now_q  <= upd_state;
			changed_q    <= state_chg;
			fired_q      <= hit_q;
			fired_slot_q <= hit_q ? 3'(slot_q) : 3'd0;
		end
	end

	assign out_valid  = out_valid_q;
	assign state_now  = state_now_q;
	assign changed    = changed_q;
	assign fired      = fired_q;
	assign fired_slot = fired_slot_q;

	// ---------------- checks ----------------
	`TFSMH_ASSERT_NEXT(a_rise_from_finish, !out_valid_q, !out_valid_q || $past(fsm_q == ST_FINISH), "result appeared outside the update step")
	`TFSMH_ASSERT_NEXT(a_scan_starts, sample_acc, fsm_q == ST_SCAN && slot_q == '0 && !hit_q, "sample did not start a scan at the first slot")
	`TFSMH_ASSERT_NOW(a_change_needs_fire, out_valid_q, !changed_q || fired_q, "state changed with no matching entry")
	`TFSMH_ASSERT_NOW(a_slot_zero_idle, out_valid_q && !fired_q, fired_slot_q == 3'd0, "slot reported without a matching entry")

endmodule

// ----- design/tfsmh_table.sv -----
// Transition table: one write port, one registered read port.
// Per-entry valid bits make unwritten entries read as empty. Uses tfsmh_pkg.
module tfsmh_table (
	input  logic                   clk,
	input  logic                   arst_n,
	input  tfsmh_pkg::tbl_wr_t     wr,
	input  logic [tfsmh_pkg::ADDR_W-1:0] rd_addr,
	output tfsmh_pkg::entry_t      rd_entry
);
	import tfsmh_pkg::*;

	entry_t               mem [TBL_DEPTH];
	logic [TBL_DEPTH-1:0] vld_q;
	entry_t               rd_data_q;
	logic                 rd_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.addr] <= 1'b1;
			end
			rd_vld_q <= vld_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rd_data_q <= mem[rd_addr];
	end

	// an entry never written reads as empty kind, zero threshold, zero target
	assign rd_entry = rd_vld_q ? rd_data_q : '0;

endmodule
